FILE: rtl/core/pnmdec_pkg.sv
// Package for the plain netpbm sample decoder.
// Holds controller states, command and status structs and character codes.
// No dependencies.
`timescale 1ns / 1ps

package pnmdec_pkg;

	localparam int unsigned VAL_W  = 16;
	localparam int unsigned LEN_W  = 4;
	localparam int unsigned DIV_W  = 24;
	localparam int unsigned CNT_W  = 5;
	localparam int unsigned ADDR_W = 3;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [VAL_W-1:0] VAL_MAX    = 16'hFFFF;
	localparam logic [VAL_W-1:0] MAXV_RESET = 16'd255;

	localparam logic REG_MAX_VALUE     = 1'b0;
	localparam logic REG_INVERT_BITMAP = 1'b1;

	typedef enum logic [1:0] {
		ST_WAIT,
		ST_COMMENT,
		ST_READ,
		ST_DIVIDE
	} ctl_state_t;

	typedef struct packed {
		logic tok_start;
		logic tok_take;
		logic div_start;
		logic div_step;
		logic emit_err;
	} ctl_cmd_t;

	typedef struct packed {
		logic is_blank;
		logic is_hash;
		logic is_lf;
		logic len_full;
		logic div_last;
		logic div_busy;
		logic out_busy;
	} dp_sts_t;

endpackage

FILE: rtl/core/pnmdec_ctrl.sv
// Controller for the plain netpbm sample decoder.
// Tracks the parse phase and sequences the divider; uses pnmdec_pkg.
`timescale 1ns / 1ps

module pnmdec_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 end_of_stream,
	input  pnmdec_pkg::dp_sts_t  sts,
	output logic                 in_stall,
	output pnmdec_pkg::ctl_cmd_t cmd
);

	pnmdec_pkg::ctl_state_t state_q;
	pnmdec_pkg::ctl_state_t state_d;
	logic                   accept;

	assign in_stall = (state_q == pnmdec_pkg::ST_DIVIDE) || sts.out_busy;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pnmdec_pkg::ST_WAIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		if (state_q == pnmdec_pkg::ST_DIVIDE) begin
			if (!(sts.div_last && sts.out_busy)) begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = pnmdec_pkg::ST_WAIT;
				end
			end
		end else if (accept && end_of_stream) begin
			if (state_q == pnmdec_pkg::ST_READ) begin
				cmd.div_start = 1'b1;
				state_d       = pnmdec_pkg::ST_DIVIDE;
			end else begin
				cmd.emit_err = 1'b1;
				state_d      = pnmdec_pkg::ST_WAIT;
			end
		end else if (accept) begin
			case (state_q)
				pnmdec_pkg::ST_COMMENT: begin
					if (sts.is_lf) begin
						state_d = pnmdec_pkg::ST_WAIT;
					end
				end
				pnmdec_pkg::ST_READ: begin
					if (sts.is_blank) begin
						cmd.div_start = 1'b1;
						state_d       = pnmdec_pkg::ST_DIVIDE;
					end else if (sts.len_full) begin
						cmd.emit_err = 1'b1;
						state_d      = pnmdec_pkg::ST_WAIT;
					end else begin
						cmd.tok_take = 1'b1;
					end
				end
				default: begin
					if (sts.is_hash) begin
						state_d = pnmdec_pkg::ST_COMMENT;
					end else if (!sts.is_blank) begin
						cmd.tok_start = 1'b1;
						state_d       = pnmdec_pkg::ST_READ;
					end else begin
						state_d = pnmdec_pkg::ST_WAIT;
					end
				end
			endcase
		end
	end

endmodule

FILE: rtl/core/pnmdec_datapath.sv
// Datapath for the plain netpbm sample decoder: token accumulator,
// restoring divider and output register. Uses pnmdec_pkg.
`timescale 1ns / 1ps

module pnmdec_datapath #(
	parameter int unsigned TOKEN_CHARS = 14
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [7:0]                         byte_in,
	input  logic [pnmdec_pkg::VAL_W-1:0]       max_value,
	input  logic                               invert_bitmap,
	input  pnmdec_pkg::ctl_cmd_t               cmd,
	output pnmdec_pkg::dp_sts_t                sts,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [7:0]                         sample_out,
	output logic                               parse_error
);

	logic [pnmdec_pkg::VAL_W-1:0] acc_q;
	logic [pnmdec_pkg::LEN_W-1:0] len_q;
	logic                         done_q;
	logic [pnmdec_pkg::DIV_W-1:0] quo_q;
	logic [pnmdec_pkg::VAL_W-1:0] rem_q;
	logic [pnmdec_pkg::CNT_W-1:0] cnt_q;
	logic                         out_valid_q;
	logic [7:0]                   sample_q;
	logic                         error_q;

	logic                         is_digit;
	logic [3:0]                   digit;
	logic [pnmdec_pkg::VAL_W-1:0] acc_base;
	logic                         done_base;
	logic [pnmdec_pkg::LEN_W-1:0] len_base;
	logic [19:0]                  acc_mul;
	logic [pnmdec_pkg::VAL_W:0]   trial;
	logic                         ge;
	logic [pnmdec_pkg::VAL_W:0]   diff;
	logic [pnmdec_pkg::DIV_W-1:0] quo_next;
	logic [pnmdec_pkg::DIV_W-1:0] dividend;
	logic                         load_div;
	logic [7:0]                   quo_byte;

	assign is_digit = (byte_in >= pnmdec_pkg::CH_ZERO) && (byte_in <= pnmdec_pkg::CH_NINE);
	assign digit    = 4'(byte_in - pnmdec_pkg::CH_ZERO);

	assign sts.is_blank = (byte_in == pnmdec_pkg::CH_SPACE) || (byte_in == pnmdec_pkg::CH_NUL)
		|| (byte_in == pnmdec_pkg::CH_LF) || (byte_in == pnmdec_pkg::CH_CR)
		|| (byte_in == pnmdec_pkg::CH_TAB);
	assign sts.is_hash  = (byte_in == pnmdec_pkg::CH_HASH);
	assign sts.is_lf    = (byte_in == pnmdec_pkg::CH_LF);
	assign sts.len_full = (len_q >= pnmdec_pkg::LEN_W'(TOKEN_CHARS));
	assign sts.div_last = (cnt_q == pnmdec_pkg::CNT_W'(1));
	assign sts.div_busy = (cnt_q != '0);
	assign sts.out_busy = out_valid_q && out_stall;

	assign acc_base  = cmd.tok_start ? '0 : acc_q;
	assign done_base = cmd.tok_start ? 1'b0 : done_q;
	assign len_base  = cmd.tok_start ? '0 : len_q;
	assign acc_mul   = {acc_base, 3'b000} + {1'b0, acc_base, 1'b0} + 20'(digit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			len_q  <= '0;
			done_q <= 1'b0;
		end else if (cmd.tok_start || cmd.tok_take) begin
			if (!done_base && is_digit) begin
				acc_q <= (acc_mul > 20'(pnmdec_pkg::VAL_MAX)) ? pnmdec_pkg::VAL_MAX
					: acc_mul[pnmdec_pkg::VAL_W-1:0];
				done_q <= done_base;
			end else begin
				acc_q  <= acc_base;
				done_q <= 1'b1;
			end
			len_q <= len_base + pnmdec_pkg::LEN_W'(1);
		end
	end

	// value*255 as (value << 8) - value
	assign dividend = {acc_q, 8'h00} - pnmdec_pkg::DIV_W'(acc_q);
	assign trial    = {rem_q, quo_q[pnmdec_pkg::DIV_W-1]};
	assign diff     = trial - {1'b0, max_value};
	assign ge       = (trial >= {1'b0, max_value});
	assign quo_next = {quo_q[pnmdec_pkg::DIV_W-2:0], ge};
	assign load_div = cmd.div_step && sts.div_last;
	assign quo_byte = invert_bitmap ? ~quo_next[7:0] : quo_next[7:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.div_start) begin
			cnt_q <= pnmdec_pkg::CNT_W'(pnmdec_pkg::DIV_W);
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q - pnmdec_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			quo_q <= quo_next;
			rem_q <= ge ? diff[pnmdec_pkg::VAL_W-1:0] : trial[pnmdec_pkg::VAL_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_div || cmd.emit_err) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_div) begin
			sample_q <= quo_byte;
			error_q  <= 1'b0;
		end else if (cmd.emit_err) begin
			sample_q <= 8'h00;
			error_q  <= 1'b1;
		end
	end

	assign out_valid   = out_valid_q;
	assign sample_out  = sample_q;
	assign parse_error = error_q;

endmodule

FILE: rtl/core/pnm_ascii_sample_decoder_core.sv
// Top level of the plain netpbm sample decoder: register port, controller
// and datapath. Uses pnmdec_pkg, pnmdec_ctrl and pnmdec_datapath.
`timescale 1ns / 1ps

// Takes one character beat per cycle, unless stalled, while parsing
// whitespace, comments and digits. A token that ends in a sample runs a
// restoring divider over the 24-bit quotient (one bit a cycle, but the last
// bit waits while the output register is full and stalled), during which
// input is stalled. A finished result waits in an output register; input
// stalls only while that register is full and stalled, or while the
// divider runs. Registers: max_value at 0x0, invert_bitmap at 0x4.
module pnm_ascii_sample_decoder_core #(
	parameter int unsigned TOKEN_CHARS = 14
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pnmdec_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    byte_in,
	input  logic                          end_of_stream,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [7:0]                    sample_out,
	output logic                          parse_error
);

	logic [pnmdec_pkg::VAL_W-1:0] max_value_q;
	logic                         invert_q;
	logic                         reg_wr;
	logic                         reg_sel;
	logic                         word_ok;
	pnmdec_pkg::ctl_cmd_t         cmd;
	pnmdec_pkg::dp_sts_t          sts;

	assign pready  = 1'b1;
	assign reg_sel = paddr[2];
	assign word_ok = (paddr[1:0] == 2'b00);
	assign reg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_value_q <= pnmdec_pkg::MAXV_RESET;
			invert_q    <= 1'b0;
		end else if (reg_wr) begin
			case (reg_sel)
				pnmdec_pkg::REG_MAX_VALUE:     max_value_q <= pwdata[pnmdec_pkg::VAL_W-1:0];
				pnmdec_pkg::REG_INVERT_BITMAP: invert_q    <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		if (word_ok) begin
			case (reg_sel)
				pnmdec_pkg::REG_MAX_VALUE:     prdata = 32'(max_value_q);
				pnmdec_pkg::REG_INVERT_BITMAP: prdata = 32'(invert_q);
				default:                       prdata = '0;
			endcase
		end
	end

	pnmdec_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.end_of_stream (end_of_stream),
		.sts           (sts),
		.in_stall      (in_stall),
		.cmd           (cmd)
	);

	pnmdec_datapath #(
		.TOKEN_CHARS (TOKEN_CHARS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.byte_in       (byte_in),
		.max_value     (max_value_q),
		.invert_bitmap (invert_q),
		.cmd           (cmd),
		.sts           (sts),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.sample_out    (sample_out),
		.parse_error   (parse_error)
	);

	a_div_starts: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> sts.div_busy)
		else $error("divider did not start");

	a_no_accept_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |-> !sts.div_busy)
		else $error("beat accepted while dividing");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_err || (cmd.div_step && sts.div_last)) |-> !(out_valid && out_stall))
		else $error("result register overwritten");

endmodule
